// ===== rtl/tefs_pkg.sv =====
// shared types and constants for the timeline event fire select block
`timescale 1ns / 1ps
package tefs_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_EVENT_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_DURATION = 2'd1;

	// field widths
	localparam int TIME_W  = 32;
	localparam int ECNT_W  = 6;
	localparam int SLOT_W  = 5;
	localparam int INDEX_W = 5;

	// results per query and result counter width
	localparam int RESULT_CAP = 32;
	localparam int NRES_W     = 6;

	// input item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic write;       // store one event time
		logic load_query;  // latch a query transaction
		logic start_pass;  // load bounds and scan counters for a pass
		logic pass_sel;    // 0: first pass, 1: second pass of a wrapped query
		logic issue;       // scan the table
		logic flush;       // emit the final result of the query
	} tefs_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic empty;      // query fires nothing by definition
		logic wrap;       // latched query crossed the loop seam
		logic scan_done;  // all entries of the pass read and compared
		logic stall;      // compare stage waits on the output register
		logic out_free;   // output register can take a result this cycle
	} tefs_stat_t;

endpackage

// ===== rtl/tefs_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tefs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/tefs_ctrl.sv =====
// controller state machine sequencing writes, scan passes and the final result
`timescale 1ns / 1ps
module tefs_ctrl
	import tefs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  tefs_stat_t st,
	output tefs_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_SCAN0 = 3'd2;
	localparam logic [2:0] S_SCAN1 = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       in_acc;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.write      = in_acc && (kind == KIND_WRITE);
				cmd.load_query = in_acc && (kind == KIND_QUERY);
				if (in_acc && (kind == KIND_QUERY)) begin
					state_d = S_START;
				end
			end
			S_START: begin
				if (st.empty) begin
					state_d = S_FLUSH;
				end else begin
					cmd.start_pass = 1'b1;
					state_d        = S_SCAN0;
				end
			end
			S_SCAN0: begin
				cmd.issue = 1'b1;
				if (st.scan_done) begin
					if (st.wrap) begin
						cmd.start_pass = 1'b1;
						cmd.pass_sel   = 1'b1;
						state_d        = S_SCAN1;
					end else begin
						state_d = S_FLUSH;
					end
				end
			end
			S_SCAN1: begin
				cmd.issue = 1'b1;
				if (st.scan_done) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (st.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/tefs_dp.sv =====
// datapath: config registers, event table, interval compare and result staging
`timescale 1ns / 1ps
module tefs_dp
	import tefs_pkg::*;
#(
	parameter int MAX_EVENTS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tefs_cmd_t            cmd,
	output tefs_stat_t           st,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data,
	input  logic [SLOT_W-1:0]    slot,
	input  logic [TIME_W-1:0]    event_time,
	input  logic [TIME_W-1:0]    time_before,
	input  logic [TIME_W-1:0]    time_after,
	input  logic                 wrapped,
	input  logic                 reversed,
	input  logic                 finished,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [INDEX_W-1:0]   fired_index,
	output logic                 fired,
	output logic                 last
);

	localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam int CW = $clog2(MAX_EVENTS + 1);

	// configuration registers
	logic [ECNT_W-1:0] event_count_q;
	logic [TIME_W-1:0] clip_duration_q;

	// latched query
	logic [TIME_W-1:0] b_q, a_q;
	logic              wrap_q, rev_q, fin_q, empty_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     cnt_d;

	// pass bounds
	logic [TIME_W-1:0] lo_q, hi_q;
	logic              lo_c_q, hi_c_q;

	// scan counters and compare stage
	logic [AW-1:0]     idx_q;
	logic [CW-1:0]     rem_q;
	logic              v_s1;
	logic [AW-1:0]     idx_s1;
	logic [TIME_W-1:0] t_s1;

	// pending result and result count
	logic              pend_v_q;
	logic [AW-1:0]     pend_idx_q;
	logic [NRES_W-1:0] nres_q;

	// output register
	logic              out_v_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic              out_fired_q, out_last_q;

	logic above, below, hit, cap_full, hit_take, stall, out_free, issue_go;
	logic slot_ok;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_count_q   <= '0;
			clip_duration_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_EVENT_COUNT) begin
				event_count_q <= cfg_data[ECNT_W-1:0];
			end else if (cfg_index == REG_CLIP_DURATION) begin
				clip_duration_q <= cfg_data;
			end
		end
	end

	// event table
	assign slot_ok = (32'(slot) < MAX_EVENTS);

	tefs_ram #(
		.WIDTH (TIME_W),
		.DEPTH (MAX_EVENTS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (cmd.write && slot_ok),
		.waddr (AW'(slot)),
		.wdata (event_time),
		.re    (!stall),
		.raddr (idx_q),
		.rdata (t_s1)
	);

	// effective entry count, clamped to the table depth
	assign cnt_d = (32'(event_count_q) > MAX_EVENTS) ? CW'(MAX_EVENTS) : CW'(event_count_q);

	// query latch
	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			b_q     <= time_before;
			a_q     <= time_after;
			wrap_q  <= wrapped;
			rev_q   <= reversed;
			fin_q   <= finished;
			cnt_q   <= cnt_d;
			empty_q <= (cnt_d == '0) || (clip_duration_q == '0)
			           || (!wrapped && (time_before == time_after));
		end
	end

	// pass bounds, picked by direction, wrap and pass
	always_ff @(posedge clk) begin
		if (cmd.start_pass) begin
			priority if (!rev_q && !wrap_q) begin
				lo_q <= b_q;  lo_c_q <= 1'b1;
				hi_q <= a_q;  hi_c_q <= fin_q;
			end else if (!rev_q && !cmd.pass_sel) begin
				lo_q <= b_q;  lo_c_q <= 1'b1;
				hi_q <= clip_duration_q;  hi_c_q <= 1'b1;
			end else if (!rev_q) begin
				lo_q <= '0;  lo_c_q <= 1'b1;
				hi_q <= (a_q < b_q) ? a_q : b_q;  hi_c_q <= 1'b0;
			end else if (!wrap_q) begin
				lo_q <= a_q;  lo_c_q <= fin_q;
				hi_q <= b_q;  hi_c_q <= 1'b1;
			end else if (!cmd.pass_sel) begin
				lo_q <= '0;  lo_c_q <= 1'b1;
				hi_q <= b_q;  hi_c_q <= 1'b1;
			end else begin
				lo_q <= (a_q > b_q) ? a_q : b_q;  lo_c_q <= 1'b0;
				hi_q <= clip_duration_q;  hi_c_q <= 1'b1;
			end
		end
	end

	// interval compare on the registered table read
	assign above    = lo_c_q ? (t_s1 >= lo_q) : (t_s1 > lo_q);
	assign below    = hi_c_q ? (t_s1 <= hi_q) : (t_s1 < hi_q);
	assign hit      = v_s1 && above && below;
	assign cap_full = (nres_q == NRES_W'(RESULT_CAP));
	assign out_free = !out_v_q || out_ready;
	assign stall    = hit && !cap_full && pend_v_q && !out_free;
	assign hit_take = hit && !cap_full && !stall;
	assign issue_go = cmd.issue && (rem_q != '0) && !stall;

	// scan counters and compare stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			rem_q <= '0;
		end else if (cmd.start_pass) begin
			v_s1  <= 1'b0;
			rem_q <= cnt_q;
		end else if (!stall) begin
			v_s1 <= issue_go;
			if (issue_go) begin
				rem_q <= rem_q - CW'(1);
			end
		end
	end

	// read index walks up or down
	always_ff @(posedge clk) begin
		if (cmd.start_pass) begin
			idx_q <= rev_q ? AW'(cnt_q - CW'(1)) : '0;
		end else if (issue_go) begin
			idx_s1 <= idx_q;
			idx_q  <= rev_q ? (idx_q - AW'(1)) : (idx_q + AW'(1));
		end
	end

	// pending result and result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			nres_q   <= '0;
		end else if (cmd.load_query) begin
			pend_v_q <= 1'b0;
			nres_q   <= '0;
		end else if (cmd.flush) begin
			pend_v_q <= 1'b0;
		end else if (hit_take) begin
			pend_v_q <= 1'b1;
			nres_q   <= nres_q + NRES_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (hit_take) begin
			pend_idx_q <= idx_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.flush || (hit_take && pend_v_q)) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush) begin
			out_idx_q   <= pend_v_q ? INDEX_W'(pend_idx_q) : '0;
			out_fired_q <= pend_v_q;
			out_last_q  <= 1'b1;
		end else if (hit_take && pend_v_q) begin
			out_idx_q   <= INDEX_W'(pend_idx_q);
			out_fired_q <= 1'b1;
			out_last_q  <= 1'b0;
		end
	end

	assign out_valid   = out_v_q;
	assign fired_index = out_idx_q;
	assign fired       = out_fired_q;
	assign last        = out_last_q;

	// status to the controller
	assign st.empty     = empty_q;
	assign st.wrap      = wrap_q;
	assign st.scan_done = (rem_q == '0) && !v_s1;
	assign st.stall     = stall;
	assign st.out_free  = out_free;

endmodule

// ===== rtl/timeline_event_fire_select.sv =====
// top level of the timeline event fire select block
`timescale 1ns / 1ps
// A write transaction (kind 0) stores one 16.16 event time in the table and
// yields no result. A query transaction (kind 1) walks the first event_count
// entries, clamped to the table depth, one entry per cycle through the
// table's single read port while the compare stage does not stall, and emits
// the index of each event inside the crossed interval, ascending for forward
// play and descending for reverse play; a wrapped query walks the table
// twice. A query holds off new input until its final result is registered.
// The last result of a query carries last; a query that fires nothing yields
// one result with fired low. The table holds no valid bits: every entry a
// query reads must have been written since reset. Configuration is to be
// written by the user only while the block is idle; it is not enforced.
module timeline_event_fire_select
	import tefs_pkg::*;
#(
	parameter int MAX_EVENTS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [SLOT_W-1:0]    slot,
	input  logic [TIME_W-1:0]    event_time,
	input  logic [TIME_W-1:0]    time_before,
	input  logic [TIME_W-1:0]    time_after,
	input  logic                 wrapped,
	input  logic                 reversed,
	input  logic                 finished,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [INDEX_W-1:0]   fired_index,
	output logic                 fired,
	output logic                 last
);

	tefs_cmd_t  cmd;
	tefs_stat_t st;

	// register writes are always accepted
	assign cfg_ready = 1'b1;

	// controller
	tefs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath
	tefs_dp #(
		.MAX_EVENTS (MAX_EVENTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.slot        (slot),
		.event_time  (event_time),
		.time_before (time_before),
		.time_after  (time_after),
		.wrapped     (wrapped),
		.reversed    (reversed),
		.finished    (finished),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.fired_index (fired_index),
		.fired       (fired),
		.last        (last)
	);

`ifndef SYNTHESIS
	// compare stage only stalls during a scan
	a_stall_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		st.stall |-> cmd.issue)
		else $error("scan stall outside a scan pass");

	// final result only goes out when the output register can take it
	a_flush_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> st.out_free)
		else $error("final result pushed into a busy output register");

	// an accepted query transaction lowers in_ready
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (kind == KIND_QUERY)) |=> !in_ready)
		else $error("input accepted while a query is running");
`endif

endmodule

// ===== tb/tefs_fire_checker.sv =====
// checker that predicts the fired event indices of each query and compares them with the block
`timescale 1ns / 1ps
module tefs_fire_checker
	import tefs_pkg::*;
#(
	parameter int MAX_EVENTS   = 32,
	parameter int REPORT_LIMIT = 200
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 kind,
	input  logic [SLOT_W-1:0]    slot,
	input  logic [TIME_W-1:0]    event_time,
	input  logic [TIME_W-1:0]    time_before,
	input  logic [TIME_W-1:0]    time_after,
	input  logic                 wrapped,
	input  logic                 reversed,
	input  logic                 finished,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [INDEX_W-1:0]   fired_index,
	input  logic                 fired,
	input  logic                 last,
	output int                   mismatches,
	output int                   due_count
);

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic               fired;
		logic               last;
	} crossing_t;

	// expected results in arrival order, and the hits of the query being predicted
	crossing_t due_crossings[$];
	crossing_t crossing_batch[$];

	// shadow of the event table and the configuration
	logic [TIME_W-1:0] stamp_table [MAX_EVENTS];
	logic [ECNT_W-1:0] active_events;
	logic [TIME_W-1:0] clip_len;

	// walk the first n entries and keep those inside the window
	function automatic void collect_window(int unsigned n, logic [TIME_W-1:0] lo, logic lo_closed,
			logic [TIME_W-1:0] hi, logic hi_closed, logic down);
		int unsigned       k;
		int unsigned       i;
		logic [TIME_W-1:0] t;
		logic              above;
		logic              below;
		crossing_t         hit;
		for (k = 0; k < n; k++) begin
			i = down ? (n - 1 - k) : k;
			t = stamp_table[i];
			above = lo_closed ? (t >= lo) : (t > lo);
			below = hi_closed ? (t <= hi) : (t < hi);
			if (above && below && crossing_batch.size() < RESULT_CAP) begin
				hit.index = INDEX_W'(i);
				hit.fired = 1'b1;
				hit.last  = 1'b0;
				crossing_batch = {crossing_batch, hit};
			end
		end
	endfunction

	// expected results of one query transaction
	function automatic void predict_crossings(logic [TIME_W-1:0] b, logic [TIME_W-1:0] a,
			logic wr, logic rv, logic fin);
		int unsigned n;
		crossing_t   r;
		crossing_batch.delete();
		n = (active_events > MAX_EVENTS) ? MAX_EVENTS : active_events;
		if (n != 0 && clip_len != 0 && (wr || b != a)) begin
			if (!rv && !wr) begin
				collect_window(n, b, 1'b1, a, fin, 1'b0);
			end else if (!rv) begin
				// seam split: tail up to the clip end, then the head clamped at time_before
				collect_window(n, b, 1'b1, clip_len, 1'b1, 1'b0);
				collect_window(n, '0, 1'b1, (a < b) ? a : b, 1'b0, 1'b0);
			end else if (!wr) begin
				collect_window(n, a, fin, b, 1'b1, 1'b1);
			end else begin
				collect_window(n, '0, 1'b1, b, 1'b1, 1'b1);
				collect_window(n, (a > b) ? a : b, 1'b0, clip_len, 1'b1, 1'b1);
			end
		end
		if (crossing_batch.size() == 0) begin
			r = '0;
			r.last = 1'b1;
			due_crossings = {due_crossings, r};
		end else begin
			foreach (crossing_batch[j]) begin
				r = crossing_batch[j];
				r.last = (j == crossing_batch.size() - 1);
				due_crossings = {due_crossings, r};
			end
		end
	endfunction

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		crossing_t got;
		crossing_t want;
		int        bad;
		if (!arst_n) begin
			due_crossings.delete();
			active_events = '0;
			clip_len      = '0;
			mismatches    = 0;
			due_count     = 0;
		end else begin
			// results first, so a stray result never meets a fresh expectation
			if (out_valid && out_ready) begin
				got = {fired_index, fired, last};
				if (due_crossings.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: unexpected result, expected none, got index %0d fired %0b last %0b",
							$time, got.index, got.fired, got.last);
					mismatches++;
				end else begin
					want = due_crossings.pop_front();
					bad = 0;
					if (got.index !== want.index) begin
						if (mismatches + bad < REPORT_LIMIT)
							$display("%0t: fired_index expected %0d got %0d",
								$time, want.index, got.index);
						bad++;
					end
					if (got.fired !== want.fired) begin
						if (mismatches + bad < REPORT_LIMIT)
							$display("%0t: fired expected %0b got %0b", $time, want.fired, got.fired);
						bad++;
					end
					if (got.last !== want.last) begin
						if (mismatches + bad < REPORT_LIMIT)
							$display("%0t: last expected %0b got %0b", $time, want.last, got.last);
						bad++;
					end
					mismatches += bad;
				end
			end

			// register writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_EVENT_COUNT)
					active_events = cfg_data[ECNT_W-1:0];
				else if (cfg_index == REG_CLIP_DURATION)
					clip_len = cfg_data;
			end

			// input transactions: table writes and queries
			if (in_valid && in_ready) begin
				if (kind == KIND_WRITE) begin
					if (slot < MAX_EVENTS)
						stamp_table[slot] = event_time;
				end else begin
					predict_crossings(time_before, time_after, wrapped, reversed, finished);
				end
			end

			due_count = due_crossings.size();
		end
	end

endmodule

// ===== tb/timeline_event_fire_select_tb.sv =====
// testbench top: stimulus, handshake pacing and verdict for the event fire select block
`timescale 1ns / 1ps
module timeline_event_fire_select_tb;
	import tefs_pkg::*;

	localparam int          CLK_PERIOD   = 20;
	localparam int          RESET_CYCLES = 8;
	localparam int          TABLE_DEPTH  = 32;
	localparam int          IDLE_PCT     = 38;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          DRAIN_CYCLES = 80;
	localparam int          SETTLE_GUARD = 200000;
	localparam longint      TIMEOUT_NS   = 64'd10_000_000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct {
		logic               kind;
		logic [SLOT_W-1:0]  slot;
		logic [TIME_W-1:0]  stamp;
		logic [TIME_W-1:0]  t_before;
		logic [TIME_W-1:0]  t_after;
		logic               wrap;
		logic               rev;
		logic               fin;
	} fire_req_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TIME_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 kind;
	logic [SLOT_W-1:0]    slot;
	logic [TIME_W-1:0]    event_time;
	logic [TIME_W-1:0]    time_before;
	logic [TIME_W-1:0]    time_after;
	logic                 wrapped;
	logic                 reversed;
	logic                 finished;
	logic                 out_valid;
	logic                 out_ready;
	logic [INDEX_W-1:0]   fired_index;
	logic                 fired;
	logic                 last;
	int                   mismatches;
	int                   due_count;

	// pacing controls: quiet_in is local to the stimulus process, the rest go to the receiver
	bit                   quiet_in;
	logic                 quiet_out;
	logic                 hold_off;
	int                   held;

	// what the stimulus knows about the table, used to aim query bounds
	logic [TIME_W-1:0]    known_stamp [TABLE_DEPTH];
	bit                   stamp_seen  [TABLE_DEPTH];
	logic [ECNT_W-1:0]    cur_count;
	logic [TIME_W-1:0]    cur_dur;

	timeline_event_fire_select dut (.*);

	tefs_fire_checker checker_i (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	// receiver: random stalls, one long hold-off, and a stall-free stretch
	initial begin
		out_ready <= 1'b0;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_off && held < HOLD_CYCLES) begin
				out_ready <= 1'b0;
				held++;
			end else if (quiet_out) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// time value aimed at the clip range, the table entries and the extremes
	function automatic logic [TIME_W-1:0] pick_time(logic [TIME_W-1:0] span);
		int unsigned roll;
		int unsigned s;
		logic [63:0] wide;
		roll = $urandom_range(99);
		s = $urandom_range(TABLE_DEPTH - 1);
		wide = {$urandom, $urandom} % ({32'd0, span} + 64'd1);
		if (roll < 8)
			return '0;
		if (roll < 14)
			return '1;
		if (roll < 20)
			return span;
		if (roll < 45 && stamp_seen[s])
			return known_stamp[s] + TIME_W'($urandom_range(2)) - 32'd1;
		if (roll < 55)
			return $urandom;
		return wide[TIME_W-1:0];
	endfunction

	// offer one input transaction, with random gaps ahead of it
	task automatic send(input fire_req_t q);
		while (!quiet_in && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= q.kind;
		slot        <= q.slot;
		event_time  <= q.stamp;
		time_before <= q.t_before;
		time_after  <= q.t_after;
		wrapped     <= q.wrap;
		reversed    <= q.rev;
		finished    <= q.fin;
		do @(posedge clk); while (!in_ready);
		if (q.kind == KIND_WRITE) begin
			known_stamp[q.slot] = q.stamp;
			stamp_seen[q.slot]  = 1'b1;
		end
	endtask

	// table write; query fields carry noise
	task automatic store(input logic [SLOT_W-1:0] s, input logic [TIME_W-1:0] stamp);
		fire_req_t q;
		q.kind     = KIND_WRITE;
		q.slot     = s;
		q.stamp    = stamp;
		q.t_before = $urandom;
		q.t_after  = $urandom;
		q.wrap     = 1'($urandom_range(1));
		q.rev      = 1'($urandom_range(1));
		q.fin      = 1'($urandom_range(1));
		send(q);
	endtask

	// fire query; write fields carry noise
	task automatic ask(input logic [TIME_W-1:0] b, input logic [TIME_W-1:0] a,
			input logic wr, input logic rv, input logic fin);
		fire_req_t q;
		q.kind     = KIND_QUERY;
		q.slot     = SLOT_W'($urandom_range(TABLE_DEPTH - 1));
		q.stamp    = $urandom;
		q.t_before = b;
		q.t_after  = a;
		q.wrap     = wr;
		q.rev      = rv;
		q.fin      = fin;
		send(q);
	endtask

	// stop offering, wait for every expected result, then let the block drain
	task automatic settle();
		int unsigned guard;
		in_valid <= 1'b0;
		guard = 0;
		do begin
			@(negedge clk);
			guard++;
		end while (due_count != 0 && guard < SETTLE_GUARD);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one register write transaction; the caller lowers valid after its last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// program both registers, then poke the unused indexes
	task automatic setup_regs(input logic [TIME_W-1:0] count_data, input logic [TIME_W-1:0] dur);
		write_reg(REG_EVENT_COUNT, count_data);
		write_reg(REG_CLIP_DURATION, dur);
		write_reg(REG_SPARE_LO, $urandom);
		write_reg(REG_SPARE_HI, $urandom);
		cfg_valid <= 1'b0;
		cur_count = count_data[ECNT_W-1:0];
		cur_dur   = dur;
	endtask

	// every entry a query may read gets written first
	task automatic fill();
		int unsigned reach;
		reach = (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : cur_count;
		for (int s = 0; s < reach; s++)
			if (!stamp_seen[s])
				store(SLOT_W'(s), pick_time((cur_dur != 0) ? cur_dur : $urandom));
	endtask

	// mostly queries, some table rewrites
	task automatic random_items(input int unsigned n);
		logic [TIME_W-1:0] span;
		logic [TIME_W-1:0] b;
		logic [TIME_W-1:0] a;
		logic [TIME_W-1:0] tmp;
		logic              wr;
		logic              rv;
		logic              fin;
		for (int unsigned i = 0; i < n; i++) begin
			span = (cur_dur != 0) ? cur_dur : $urandom;
			if ($urandom_range(99) < 22) begin
				store(SLOT_W'($urandom_range(TABLE_DEPTH - 1)), pick_time(span));
			end else begin
				wr  = ($urandom_range(99) < 30);
				rv  = 1'($urandom_range(1));
				fin = ($urandom_range(99) < 30);
				b   = pick_time(span);
				a   = pick_time(span);
				// mostly keep unwrapped intervals in the direction of play
				if (!wr && $urandom_range(99) < 75 && (rv ? (a > b) : (b > a))) begin
					tmp = a;
					a   = b;
					b   = tmp;
				end
				if ($urandom_range(99) < 6)
					a = b;
				ask(b, a, wr, rv, fin);
			end
		end
	endtask

	task automatic run_phase(input logic [TIME_W-1:0] count_data, input logic [TIME_W-1:0] dur,
			input int unsigned n);
		settle();
		setup_regs(count_data, dur);
		fill();
		random_items(n);
	endtask

	// main sequence
	initial begin
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= REG_EVENT_COUNT;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		kind        <= KIND_WRITE;
		slot        <= '0;
		event_time  <= '0;
		time_before <= '0;
		time_after  <= '0;
		wrapped     <= 1'b0;
		reversed    <= 1'b0;
		finished    <= 1'b0;
		hold_off    <= 1'b0;
		quiet_out   <= 1'b0;
		quiet_in    = 1'b0;
		cur_count   = '0;
		cur_dur     = '0;
		foreach (known_stamp[s]) begin
			known_stamp[s] = '0;
			stamp_seen[s]  = 1'b0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no events configured after reset
		ask(32'h0000_0000, 32'h0001_0000, 1'b0, 1'b0, 1'b0);

		// small table with a duplicate time and both time extremes
		store(5'd0, 32'h0000_0000);
		store(5'd1, 32'h0001_0000);
		store(5'd2, 32'h0002_8000);
		store(5'd3, 32'h0004_0000);
		store(5'd4, 32'h0004_0000);
		store(5'd5, 32'h0008_0000);
		store(5'd6, 32'hFFFF_FFFF);
		store(5'd7, 32'h0003_0000);

		// zero clip length disables firing
		settle();
		setup_regs(32'd8, 32'd0);
		ask(32'h0001_0000, 32'h0004_0000, 1'b0, 1'b0, 1'b0);

		settle();
		setup_regs(32'd8, 32'h000A_0000);
		// forward, open and closed far end
		ask(32'h0001_0000, 32'h0004_0000, 1'b0, 1'b0, 1'b0);
		ask(32'h0001_0000, 32'h0004_0000, 1'b0, 1'b0, 1'b1);
		// zero-width unwrapped, then the same width across the seam
		ask(32'h0003_0000, 32'h0003_0000, 1'b0, 1'b0, 1'b0);
		ask(32'h0003_0000, 32'h0003_0000, 1'b1, 1'b0, 1'b0);
		// forward across the seam
		ask(32'h0003_0000, 32'h0001_8000, 1'b1, 1'b0, 1'b0);
		// reverse, open and closed far end
		ask(32'h0004_0000, 32'h0001_0000, 1'b0, 1'b1, 1'b0);
		ask(32'h0004_0000, 32'h0001_0000, 1'b0, 1'b1, 1'b1);
		// reverse across the seam, both orders of the bounds
		ask(32'h0002_0000, 32'h0008_0000, 1'b1, 1'b1, 1'b0);
		ask(32'h0006_0000, 32'h0001_0000, 1'b1, 1'b1, 1'b1);
		// nothing in the interval
		ask(32'h0009_0000, 32'h0009_8000, 1'b0, 1'b0, 1'b0);
		// full time range both ways
		ask(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);
		ask(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, 1'b1);
		// forward interval given backwards
		ask(32'h0008_0000, 32'h0001_0000, 1'b0, 1'b0, 1'b0);

		// random phases over several settings
		run_phase(32'd32, 32'hFFFF_FFFF, 12);
		run_phase(32'd1, 32'h0002_0000, 12);
		run_phase($urandom_range(31, 2), $urandom, 12);

		// count above the table size, receiver holds off while the sender keeps pushing
		quiet_in = 1'b1;
		hold_off <= 1'b1;
		run_phase(($urandom & ~32'h3F) | 32'h3F, $urandom, 12);
		hold_off <= 1'b0;
		quiet_in = 1'b0;

		run_phase(32'd0, $urandom, 5);
		run_phase($urandom_range(32, 1), 32'd0, 5);

		// no idling on either side
		quiet_in = 1'b1;
		quiet_out <= 1'b1;
		run_phase(32'd32, $urandom, 12);
		quiet_out <= 1'b0;
		quiet_in = 1'b0;

		// clip of one least significant bit
		run_phase($urandom_range(32, 1), 32'd1, 12);

		settle();
		@(negedge clk);
		if (mismatches == 0 && due_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tefs_pkg.sv
rtl/tefs_ram.sv
rtl/tefs_ctrl.sv
rtl/tefs_dp.sv
rtl/timeline_event_fire_select.sv
tb/tefs_fire_checker.sv
tb/timeline_event_fire_select_tb.sv
